// ===== rtl/sdp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdp_pkg
// Shared types and character constants for the signed decimal parser.
// ----------------------------------------------------------------------------
package sdp_pkg;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } sdp_phase_t;

  // what one parse step asks of the result register
  typedef struct packed {
    logic emit;
    logic ok;
  } sdp_res_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned BASE_W  = 16;

endpackage

// ===== rtl/signed_decimal_parser_top.sv =====
// ----------------------------------------------------------------------------
// signed_decimal_parser_top
// Parses a signed decimal integer from a byte stream, one character an item.
// ----------------------------------------------------------------------------
// Path: an accepted character passes through the input register, then the parse
// step into the result register.
// Throughput: one character per cycle unless the output stalls; the multiply-by-ten
// shift-add and the sign negation sit in the single step between the two registers.
// Reset: synchronous rst clears the pipeline valids and parse state; the next
// item starts a new string.
module signed_decimal_parser_top import sdp_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [23:0]                       s_axis_tdata,  // char_byte[7:0], base_index[23:8]
  input  logic                              s_axis_tlast,  // last_char
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((32+INDEX_WIDTH+7)/8)*8-1:0] m_axis_tdata, // parsed_value, end_index, zero pad
  output logic                              m_axis_tuser   // parse_ok
);

  localparam int unsigned OUT_W = ((32 + INDEX_WIDTH + 7) / 8) * 8;
  localparam int unsigned PAD_W = OUT_W - VALUE_W - INDEX_WIDTH;

  // input register
  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   in_last;
  logic [BASE_W-1:0]      in_base;

  // parse state
  sdp_phase_t             phase;
  logic [VALUE_W-1:0]     acc;
  logic                   neg;
  logic [INDEX_WIDTH-1:0] pos;
  logic                   first;

  sdp_phase_t             phase_next;
  logic [VALUE_W-1:0]     acc_next;
  logic                   neg_next;
  logic [INDEX_WIDTH-1:0] pos_next;
  logic                   first_next;
  sdp_res_t               res;
  logic [VALUE_W-1:0]     value;
  logic [INDEX_WIDTH-1:0] end_idx;

  // result register
  logic                   out_valid;
  logic [VALUE_W-1:0]     out_value;
  logic [INDEX_WIDTH-1:0] out_end;
  logic                   out_ok;

  logic                   step_en;

  assign step_en       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step_en;

  sdp_step #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_step (
    .char_byte (in_byte),
    .last_char (in_last),
    .base_index(in_base),
    .phase     (phase),
    .acc       (acc),
    .neg       (neg),
    .pos       (pos),
    .first     (first),
    .phase_next(phase_next),
    .acc_next  (acc_next),
    .neg_next  (neg_next),
    .pos_next  (pos_next),
    .first_next(first_next),
    .res       (res),
    .value     (value),
    .end_idx   (end_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata[7:0];
      in_base <= s_axis_tdata[23:8];
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SPACE;
      acc   <= '0;
      neg   <= 1'b0;
      pos   <= '0;
      first <= 1'b1;
    end else if (step_en) begin
      phase <= phase_next;
      acc   <= acc_next;
      neg   <= neg_next;
      pos   <= pos_next;
      first <= first_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= step_en && res.emit;
    end
    if (step_en && res.emit) begin
      out_value <= value;
      out_end   <= end_idx;
      out_ok    <= res.ok;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_end, out_value};
  assign m_axis_tuser  = out_ok;

endmodule

// ===== rtl/sdp_step.sv =====
// ----------------------------------------------------------------------------
// sdp_step
// One parse step: takes the current parse state and one character, gives
// the next state and, when the parse ends, the result.
// ----------------------------------------------------------------------------
module sdp_step import sdp_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic [7:0]             char_byte,
  input  logic                   last_char,
  input  logic [BASE_W-1:0]      base_index,
  input  sdp_phase_t             phase,
  input  logic [VALUE_W-1:0]     acc,
  input  logic                   neg,
  input  logic [INDEX_WIDTH-1:0] pos,
  input  logic                   first,
  output sdp_phase_t             phase_next,
  output logic [VALUE_W-1:0]     acc_next,
  output logic                   neg_next,
  output logic [INDEX_WIDTH-1:0] pos_next,
  output logic                   first_next,
  output sdp_res_t               res,
  output logic [VALUE_W-1:0]     value,
  output logic [INDEX_WIDTH-1:0] end_idx
);

  localparam logic [32:0] IDX_MAX_W = (33'd1 << INDEX_WIDTH) - 33'd1;
  localparam logic [INDEX_WIDTH-1:0] IDX_MAX = '1;

  sdp_phase_t             ph;
  logic [VALUE_W-1:0]     acc_cur;
  logic                   neg_cur;
  logic [INDEX_WIDTH-1:0] pos_cur;
  logic [INDEX_WIDTH-1:0] pos_adv;
  logic [INDEX_WIDTH-1:0] base_sat;
  logic                   is_space;
  logic                   is_digit;
  logic                   is_sign;
  logic [VALUE_W-1:0]     digit;
  logic [VALUE_W-1:0]     acc_mac;

  always_comb begin
    if ({17'd0, base_index} > IDX_MAX_W) begin
      base_sat = IDX_MAX;
    end else begin
      base_sat = INDEX_WIDTH'(base_index);
    end
  end

  // a new string starts from a clean state at its base index
  assign ph      = first ? PH_SPACE : phase;
  assign acc_cur = first ? '0 : acc;
  assign neg_cur = first ? 1'b0 : neg;
  assign pos_cur = first ? base_sat : pos;
  assign pos_adv = (pos_cur == IDX_MAX) ? pos_cur : pos_cur + 1'b1;

  assign is_space = (char_byte == CH_SPACE) || (char_byte >= CH_TAB && char_byte <= CH_CR);
  assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign is_sign  = (char_byte == CH_PLUS) || (char_byte == CH_MINUS);
  assign digit    = {{(VALUE_W-4){1'b0}}, char_byte[3:0]};
  // acc * 10 + d as shift-add
  assign acc_mac  = (acc_cur << 3) + (acc_cur << 1) + digit;

  assign first_next = last_char;

  always_comb begin
    phase_next = ph;
    acc_next   = acc_cur;
    neg_next   = neg_cur;
    pos_next   = pos_cur;
    res        = '0;
    unique case (ph)
      PH_SPACE: begin
        if (is_space) begin
          pos_next = pos_adv;
          if (last_char) begin
            res.emit   = 1'b1;
            phase_next = PH_DONE;
          end
        end else if (is_sign) begin
          neg_next   = (char_byte == CH_MINUS);
          phase_next = PH_SIGN;
          pos_next   = pos_adv;
          if (last_char) begin
            res.emit   = 1'b1;
            phase_next = PH_DONE;
          end
        end else if (is_digit) begin
          acc_next   = digit;
          phase_next = PH_DIGITS;
          pos_next   = pos_adv;
          if (last_char) begin
            res.emit   = 1'b1;
            res.ok     = 1'b1;
            phase_next = PH_DONE;
          end
        end else begin
          res.emit   = 1'b1;
          phase_next = PH_DONE;
        end
      end
      PH_SIGN: begin
        if (is_digit) begin
          acc_next   = digit;
          phase_next = PH_DIGITS;
          pos_next   = pos_adv;
          if (last_char) begin
            res.emit   = 1'b1;
            res.ok     = 1'b1;
            phase_next = PH_DONE;
          end
        end else begin
          res.emit   = 1'b1;
          phase_next = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (is_digit || char_byte == CH_COMMA) begin
          if (is_digit) begin
            acc_next = acc_mac;
          end
          pos_next = pos_adv;
          if (last_char) begin
            res.emit   = 1'b1;
            res.ok     = 1'b1;
            phase_next = PH_DONE;
          end
        end else begin
          // stop byte, not consumed
          res.emit   = 1'b1;
          res.ok     = 1'b1;
          phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // failure reports zeros
  assign value   = !res.ok ? '0 : (neg_next ? (VALUE_W'(0) - acc_next) : acc_next);
  assign end_idx = !res.ok ? '0 : pos_next;

endmodule

// ===== rtl/sdp_checker.sv =====
// ----------------------------------------------------------------------------
// sdp_checker
// Port-level checks for the signed decimal parser, bound to the top level.
// ----------------------------------------------------------------------------
module sdp_checker #(
  parameter int unsigned INDEX_WIDTH = 16
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [((32+INDEX_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input logic                                m_axis_tuser
);

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // a failed parse carries all zeros
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("failure result has non-zero data");

  // a success consumed at least one digit, so the end index is past the base (or held at its top value) and non-zero
  a_ok_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[32 +: INDEX_WIDTH] != '0)
    else $error("success with zero end index");

  // with the output free the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output empty");

endmodule

bind signed_decimal_parser_top sdp_checker #(
  .INDEX_WIDTH(INDEX_WIDTH)
) u_sdp_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
